>>> hdl/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants of the merge sort buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package msb_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // buffer port control from the sequencer to the RAM pair
  typedef struct packed {
    logic we;      // write enable
    logic wr_buf;  // buffer written
    logic rd_buf;  // buffer read
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> hdl/msb_in_if.sv
// ----------------------------------------------------------------------------
// msb_in_if
// Input request channel: one element of a run, last marks the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none

interface msb_in_if;
  logic             valid;
  logic             ready;
  msb_pkg::value_t  value;
  logic             last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/msb_out_if.sv
// ----------------------------------------------------------------------------
// msb_out_if
// Result request channel: sorted elements, last one marked.
// ----------------------------------------------------------------------------
`default_nettype none

interface msb_out_if;
  logic             valid;
  logic             ready;
  msb_pkg::value_t  sorted_value;
  logic             last_out;
  logic             overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/msb_ram.sv
// ----------------------------------------------------------------------------
// msb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/msb_ctrl.sv
// ----------------------------------------------------------------------------
// msb_ctrl
// Sequencer: loads a run, merges it bottom-up between two buffers through one
// shared compare unit, then streams the sorted run out.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  msb_in_if.sink                        in_chan,
  msb_out_if.source                     out_chan,
  output msb_pkg::mem_ctl_t             mem_ctl,
  output logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [$clog2(DEPTH)-1:0]      waddr,
  output msb_pkg::value_t               wdata,
  input  wire msb_pkg::value_t          rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_FA,
    S_FB,
    S_STEP,
    S_OUT_RD,
    S_OUT_LOAD,
    S_OUT_SHOW
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic [SW-1:0]    width_r, width_nxt;
  logic [SW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    mid_r, mid_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  msb_pkg::value_t  ha_r, ha_nxt;
  msb_pkg::value_t  hb_r, hb_nxt;
  logic             fresh_a_r, fresh_a_nxt;
  logic             fresh_b_r, fresh_b_nxt;
  logic             src_r, src_nxt;
  logic             out_valid_r, out_valid_nxt;
  msb_pkg::value_t  out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic [SW-1:0]    n_ext;
  logic [SW-1:0]    mid_sum, hi_sum, lo_next;
  logic [CW-1:0]    mid_clamp, hi_clamp;
  logic [CW-1:0]    i_inc, j_inc, k_inc;
  msb_pkg::value_t  cur_a, cur_b;
  logic             a_ok, b_ok, take_a;

  assign in_chan.ready         = (state_r == S_LOAD);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.sorted_value = out_value_r;
  assign out_chan.last_out     = out_last_r;
  assign out_chan.overflow     = out_ovf_r;

  // merge bounds and compare unit
  assign n_ext     = {1'b0, count_r};
  assign mid_sum   = lo_r + width_r;
  assign hi_sum    = lo_r + {width_r[SW-2:0], 1'b0};
  assign lo_next   = hi_sum;
  assign mid_clamp = (mid_sum > n_ext) ? count_r : mid_sum[CW-1:0];
  assign hi_clamp  = (hi_sum > n_ext) ? count_r : hi_sum[CW-1:0];
  assign i_inc     = i_r + CW'(1);
  assign j_inc     = j_r + CW'(1);
  assign k_inc     = k_r + CW'(1);
  assign cur_a     = fresh_a_r ? rdata : ha_r;
  assign cur_b     = fresh_b_r ? rdata : hb_r;
  assign a_ok      = (i_r < mid_r);
  assign b_ok      = (j_r < hi_r);
  assign take_a    = a_ok && (!b_ok || (cur_a <= cur_b));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    width_nxt     = width_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    ha_nxt        = ha_r;
    hb_nxt        = hb_r;
    fresh_a_nxt   = fresh_a_r;
    fresh_b_nxt   = fresh_b_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    mem_ctl       = '0;
    mem_ctl.rd_buf = src_r;
    raddr         = '0;
    waddr         = '0;
    wdata         = in_chan.value;

    unique case (state_r)
      S_LOAD: begin
        if (in_chan.valid) begin
          if (count_r < CW'(DEPTH)) begin
            mem_ctl.we     = 1'b1;
            mem_ctl.wr_buf = 1'b0;
            waddr          = count_r[AW-1:0];
            count_nxt      = count_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_chan.last) begin
            width_nxt = SW'(1);
            src_nxt   = 1'b0;
            state_nxt = S_PASS;
          end
        end
      end

      S_PASS: begin
        if (width_r >= n_ext) begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          lo_nxt    = '0;
          state_nxt = S_FA;
        end
      end

      S_FA: begin
        mid_nxt   = mid_clamp;
        hi_nxt    = hi_clamp;
        i_nxt     = lo_r[CW-1:0];
        j_nxt     = mid_clamp;
        k_nxt     = lo_r[CW-1:0];
        raddr     = lo_r[AW-1:0];
        state_nxt = S_FB;
      end

      S_FB: begin
        raddr       = j_r[AW-1:0];
        ha_nxt      = rdata;
        fresh_a_nxt = 1'b0;
        fresh_b_nxt = 1'b1;
        state_nxt   = S_STEP;
      end

      S_STEP: begin
        ha_nxt         = cur_a;
        hb_nxt         = cur_b;
        mem_ctl.we     = 1'b1;
        mem_ctl.wr_buf = !src_r;
        waddr          = k_r[AW-1:0];
        wdata          = take_a ? cur_a : cur_b;
        k_nxt          = k_inc;
        if (take_a) begin
          i_nxt       = i_inc;
          raddr       = i_inc[AW-1:0];
          fresh_a_nxt = 1'b1;
          fresh_b_nxt = 1'b0;
        end else begin
          j_nxt       = j_inc;
          raddr       = j_inc[AW-1:0];
          fresh_a_nxt = 1'b0;
          fresh_b_nxt = 1'b1;
        end
        if (k_inc == hi_r) begin
          if (lo_next < n_ext) begin
            lo_nxt    = lo_next;
            state_nxt = S_FA;
          end else begin
            width_nxt = {width_r[SW-2:0], 1'b0};
            src_nxt   = !src_r;
            state_nxt = S_PASS;
          end
        end
      end

      S_OUT_RD: begin
        raddr     = k_r[AW-1:0];
        state_nxt = S_OUT_LOAD;
      end

      S_OUT_LOAD: begin
        out_value_nxt = rdata;
        out_last_nxt  = (k_inc == count_r);
        out_ovf_nxt   = drop_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT_SHOW;
      end

      S_OUT_SHOW: begin
        raddr = k_inc[AW-1:0];
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_OUT_LOAD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    width_r     <= width_nxt;
    lo_r        <= lo_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    ha_r        <= ha_nxt;
    hb_r        <= hb_nxt;
    fresh_a_r   <= fresh_a_nxt;
    fresh_b_r   <= fresh_b_nxt;
    src_r       <= src_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/merge_sort_buffer_top.sv
// Loading accepts one input request per cycle; after the last request, sorting does
//   n*ceil(log2 n) merge steps, a fetch of both run heads per merge and ceil(log2 n)+1 pass checks.
// Results then stream out one at a time, each read from a buffer and held until taken;
//   sorting speed is set by the single compare unit and one read port.
// Input is not ready from the last request until the last result is taken.
// Reset (rst_n, synchronous) clears the count, overflow flag and sequencer; buffers keep data.
// ----------------------------------------------------------------------------
// merge_sort_buffer_top
// Buffers a run of signed values and returns it sorted ascending (stable).
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sort_buffer_top #(
  parameter int DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  msb_in_if.sink     in_chan,
  msb_out_if.source  out_chan
);

  localparam int AW = $clog2(DEPTH);

  msb_pkg::mem_ctl_t  mem_ctl;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  msb_pkg::value_t    wdata;
  msb_pkg::value_t    rdata;
  logic [msb_pkg::VALUE_W-1:0] rdata0, rdata1;
  logic               we0, we1;

  assign we0   = mem_ctl.we && !mem_ctl.wr_buf;
  assign we1   = mem_ctl.we &&  mem_ctl.wr_buf;
  assign rdata = mem_ctl.rd_buf ? msb_pkg::value_t'(rdata1) : msb_pkg::value_t'(rdata0);

  msb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .mem_ctl  (mem_ctl),
    .raddr    (raddr),
    .waddr    (waddr),
    .wdata    (wdata),
    .rdata    (rdata)
  );

  msb_ram #(.WIDTH(msb_pkg::VALUE_W), .DEPTH(DEPTH)) u_buf0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  msb_ram #(.WIDTH(msb_pkg::VALUE_W), .DEPTH(DEPTH)) u_buf1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

endmodule

`default_nettype wire

>>> tb/merge_sort_buffer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_sort_buffer_top_test
// Sends runs of signed values into the merge sort buffer and checks every
// sorted result against a stable sort kept in the bench. Covers single-element
// runs, sign extremes, ties, full and overflowing buffers, and random runs
// under three idle/stall mixes.
// ----------------------------------------------------------------------------

module merge_sort_buffer_top_test;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 200;

  localparam msb_pkg::value_t VAL_MIN = 32'sh8000_0000;
  localparam msb_pkg::value_t VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    msb_pkg::value_t value;
    logic            last;
  } elem_req_t;

  typedef struct packed {
    msb_pkg::value_t value;
    logic            last_out;
    logic            overflow;
  } sorted_res_t;

  logic clk;
  logic rst_n;

  msb_in_if  in_chan ();
  msb_out_if out_chan ();

  merge_sort_buffer_top #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  elem_req_t       elem_backlog[$];
  sorted_res_t     sorted_expect[$];
  msb_pkg::value_t run_values[$];
  logic            run_dropped;
  int              err_count;
  int              cycle_count;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              queued_items;

  // collect one accepted element; a marked one closes the run and yields
  // its stable ascending order
  function automatic void absorb_element(msb_pkg::value_t v, logic is_last);
    msb_pkg::value_t ordered[$];
    int              pos;
    if (run_values.size() < DEPTH) begin
      run_values.push_back(v);
    end else begin
      run_dropped = 1'b1;
    end
    if (is_last) begin
      foreach (run_values[i]) begin
        pos = ordered.size();
        while (pos > 0 && ordered[pos-1] > run_values[i]) pos--;
        ordered.insert(pos, run_values[i]);
      end
      foreach (ordered[i]) begin
        sorted_expect.push_back('{ordered[i], logic'(i == ordered.size() - 1), run_dropped});
      end
      run_values.delete();
      run_dropped = 1'b0;
    end
  endfunction

  function automatic msb_pkg::value_t pick_value();
    msb_pkg::value_t v;
    case ($urandom_range(0, 3))
      0: v = msb_pkg::value_t'($urandom_range(0, 8)) - msb_pkg::value_t'(4);
      1: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = msb_pkg::value_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_elem(msb_pkg::value_t v, logic is_last);
    elem_backlog.push_back('{v, is_last});
    queued_items++;
  endtask

  task automatic queue_run(int len);
    for (int i = 0; i < len; i++) queue_elem(pick_value(), logic'(i == len - 1));
  endtask

  task automatic wait_drained();
    while (elem_backlog.size() != 0 || in_chan.valid || sorted_expect.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int s_pct, int r_pct, int n_items);
    int target;
    target = queued_items + n_items;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (queued_items < target) begin
      if ($urandom_range(0, 11) == 0) queue_run($urandom_range(60, 70));
      else queue_run($urandom_range(1, 12));
    end
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("merge_sort_buffer_top_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_in
    elem_req_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) absorb_element(in_chan.value, in_chan.last);
      if (!in_chan.valid || in_chan.ready) begin
        if (elem_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = elem_backlog.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.value <= nxt.value;
          in_chan.last  <= nxt.last;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_out
    sorted_res_t want;
    out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (sorted_expect.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result value=%0d last=%b overflow=%b", $time,
                 out_chan.sorted_value, out_chan.last_out, out_chan.overflow);
      end else begin
        want = sorted_expect.pop_front();
        if (out_chan.sorted_value !== want.value || out_chan.last_out !== want.last_out ||
            out_chan.overflow !== want.overflow) begin
          err_count++;
          $display("%0t: expected value=%0d last=%b overflow=%b, got value=%0d last=%b overflow=%b",
                   $time, want.value, want.last_out, want.overflow,
                   out_chan.sorted_value, out_chan.last_out, out_chan.overflow);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    in_chan.last   = 1'b0;
    out_chan.ready = 1'b0;
    run_dropped    = 1'b0;
    err_count      = 0;
    cycle_count    = 0;
    queued_items   = 0;
    send_idle_pct  = 25;
    recv_idle_pct  = 61;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // single elements at both extremes
    queue_elem(VAL_MIN, 1'b1);
    queue_elem(VAL_MAX, 1'b1);
    // sign boundary and bit patterns
    queue_elem('0, 1'b0);
    queue_elem('1, 1'b0);
    queue_elem(VAL_MAX, 1'b0);
    queue_elem(VAL_MIN, 1'b0);
    queue_elem(32'sh5555_5555, 1'b0);
    queue_elem(32'shaaaa_aaaa, 1'b0);
    queue_elem(32'sd1, 1'b1);
    // ties
    queue_elem(32'sd5, 1'b0);
    queue_elem(32'sd5, 1'b0);
    queue_elem(-32'sd5, 1'b0);
    queue_elem(32'sd5, 1'b1);
    // descending
    queue_elem(32'sd3, 1'b0);
    queue_elem(32'sd2, 1'b0);
    queue_elem(32'sd1, 1'b0);
    queue_elem(32'sd0, 1'b1);
    wait_drained();

    // exactly full, marked element dropped, and several dropped
    queue_run(DEPTH);
    queue_run(DEPTH + 1);
    queue_run(DEPTH + 6);

    run_phase(25, 61, 60);
    run_phase(61, 25, 60);
    run_phase(0, 0, 60);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("merge_sort_buffer_top_test: clean");
    end else begin
      $display("merge_sort_buffer_top_test: errors");
    end
    $finish;
  end

endmodule

>>> merge_sort_buffer_top.f
hdl/msb_pkg.sv
hdl/msb_in_if.sv
hdl/msb_out_if.sv
hdl/msb_ram.sv
hdl/msb_ctrl.sv
hdl/merge_sort_buffer_top.sv
tb/merge_sort_buffer_top_test.sv
